>>> hdl/dosr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the drop-oldest sample ring.
// No dependencies; every other file of the block imports this package.
package dosr_pkg;

    localparam int DEPTH     = 64;
    localparam int SAMPLE_W  = 64;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 7;
    localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(40);

    typedef enum logic [1:0] {
        CMD_PUSH     = 2'd0,
        CMD_POP      = 2'd1,
        CMD_TAKE_OVF = 2'd2,
        CMD_CLEAR    = 2'd3
    } dosr_cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } dosr_state_t;

    typedef struct packed {
        dosr_cmd_t           cmd;
        logic [SAMPLE_W-1:0] sample_word;
    } dosr_in_t;

    typedef struct packed {
        logic                pop_valid;
        logic [SAMPLE_W-1:0] sample_out;
        logic                dropped_oldest;
        logic                overflow_seen;
        logic [CNT_W-1:0]    occupancy;
    } dosr_out_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } dosr_ram_ctl_t;

endpackage

>>> hdl/dosr_ram.sv
`timescale 1ns / 1ps
// Single-port-write, single-port-read synchronous sample RAM with a registered read port.
// Uses dosr_pkg for the control struct.
module dosr_ram #(
    parameter int DATA_W = 64,
    parameter int ADDR_W = 6
) (
    input  logic                  clk,
    input  dosr_pkg::dosr_ram_ctl_t ctl,
    input  logic [DATA_W-1:0]     wdata,
    output logic [DATA_W-1:0]     rdata
);
    import dosr_pkg::*;

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[ctl.waddr[ADDR_W-1:0]] <= wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[ctl.raddr[ADDR_W-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/drop_oldest_sample_ring.sv
`timescale 1ns / 1ps
// Drop-oldest sample ring: a circular queue of sample words in a synchronous RAM whose
// active capacity comes from a 7-bit register (0 acts as 1, above DEPTH acts as DEPTH).
// Each accepted word carries one command: push, pop, read-and-clear overflow, or clear,
// and yields exactly one result word. Push, read-and-clear and clear are answered from
// the output register; a pop of a non-empty queue goes via the RAM read register and ST_POP.
// If the capacity shrank to or below the head pointer without a clear, the head is first
// reduced by repeated subtraction of the capacity, one subtraction per cycle, while input
// stalls. Issue a clear after changing the capacity.
// Depends on dosr_pkg and dosr_ram.
module drop_oldest_sample_ring (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [dosr_pkg::CAP_W-1:0] cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  dosr_pkg::dosr_in_t       in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output dosr_pkg::dosr_out_t      out_data
);
    import dosr_pkg::*;

    // Configuration register
    logic [CAP_W-1:0] cap_cfg_reg;

    // Ring control state
    dosr_state_t      state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;

    // Output register
    logic             out_valid_reg, out_valid_next;
    dosr_out_t        out_data_reg, out_data_next;

    dosr_ram_ctl_t       ram_ctl;
    logic [SAMPLE_W-1:0] ram_rdata;

    logic [CMP_W-1:0] cfg_ext;
    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] head_ext;
    logic [CNT_W:0]   slot_sum;
    logic [CNT_W-1:0] head_inc;
    logic [CNT_W-1:0] push_cnt;
    logic [IDX_W-1:0] push_head;
    logic             head_ok;
    logic             out_free;
    logic             in_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_cfg_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_cfg_reg <= cfg_wdata;
        end
    end

    // Clamp the capacity register into 1..DEPTH.
    always_comb
    begin
        cfg_ext = CMP_W'(cap_cfg_reg);
        if (cfg_ext == '0)
            cap = CNT_W'(1);
        else if (cfg_ext > CMP_W'(DEPTH))
            cap = CNT_W'(DEPTH);
        else
            cap = CNT_W'(cfg_ext);
    end

    assign head_ext  = CNT_W'(head_reg);
    assign head_ok   = (head_ext < cap);
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && head_ok && out_free);
    assign in_accept = in_valid && !in_stall;

    // Push into a full ring: advance the head past the dropped word first.
    always_comb
    begin
        head_inc = head_ext + CNT_W'(1);
        if (count_reg >= cap)
        begin
            push_head = (head_inc == cap) ? '0 : IDX_W'(head_inc);
            push_cnt  = cap - CNT_W'(1);
        end
        else
        begin
            push_head = head_reg;
            push_cnt  = count_reg;
        end
        // head and count are both below cap, so one subtract wraps the slot.
        slot_sum = (CNT_W + 1)'(push_head) + (CNT_W + 1)'(push_cnt);
        if (slot_sum >= (CNT_W + 1)'(cap))
            slot_sum = slot_sum - (CNT_W + 1)'(cap);
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        ram_ctl        = '0;
        ram_ctl.waddr  = IDX_W'(slot_sum);
        ram_ctl.raddr  = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!head_ok)
                begin
                    // Reduce a stale head after a capacity change, one step a cycle.
                    head_next = IDX_W'(head_ext - cap);
                end
                else if (in_accept)
                begin
                    out_data_next = '0;
                    unique case (in_data.cmd)
                        CMD_PUSH:
                        begin
                            ram_ctl.we   = 1'b1;
                            head_next    = push_head;
                            count_next   = push_cnt + CNT_W'(1);
                            if (count_reg >= cap)
                            begin
                                ovf_next                     = 1'b1;
                                out_data_next.dropped_oldest = 1'b1;
                            end
                            out_data_next.occupancy = push_cnt + CNT_W'(1);
                            out_valid_next          = 1'b1;
                        end
                        CMD_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                // Launch the read; the word leaves once data returns.
                                ram_ctl.re              = 1'b1;
                                head_next               = (head_inc == cap) ? '0
                                                          : IDX_W'(head_inc);
                                count_next              = count_reg - CNT_W'(1);
                                out_data_next.pop_valid = 1'b1;
                                out_data_next.occupancy = count_reg - CNT_W'(1);
                                state_next              = ST_POP;
                            end
                            else
                            begin
                                out_data_next.occupancy = count_reg;
                                out_valid_next          = 1'b1;
                            end
                        end
                        CMD_TAKE_OVF:
                        begin
                            out_data_next.overflow_seen = ovf_reg;
                            out_data_next.occupancy     = count_reg;
                            ovf_next                    = 1'b0;
                            out_valid_next              = 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            head_next      = '0;
                            count_next     = '0;
                            ovf_next       = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            out_valid_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                // Output register is empty here: it was free when the pop was taken.
                out_data_next.sample_out = ram_rdata;
                out_valid_next           = 1'b1;
                state_next               = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload register: no reset needed.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    dosr_ram #(
        .DATA_W (SAMPLE_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .wdata (in_data.sample_word),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Held count never exceeds the ring depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // The pop data cycle must find the output register empty.
    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> !out_valid_reg)
        else $error("pop data would overwrite a pending word");

    // A word is only taken with the head already inside the ring.
    a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> head_ok)
        else $error("word accepted with stale head");

    // A pop of a non-empty ring moves to the data-return cycle.
    a_pop_launch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_data.cmd == CMD_POP) && (count_reg != '0))
        |=> (state_reg == ST_POP))
        else $error("pop did not launch RAM read");

endmodule
